// ===== hw/rtl/sptt_pkg.sv =====
// Shared constants, types and command codes for the sorted priority task table.
`default_nettype none

package sptt_pkg;

  localparam int DEPTH         = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int ADDR_W        = $clog2(DEPTH);
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int MODE_W        = 2;
  localparam int ID_W          = 16;
  localparam int PRIO_IN_W     = 8;
  localparam int PRIO_OUT_W    = 8;
  localparam int REMOVED_W     = 5;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ID_W-1:0]          id_t;
  typedef logic [PRIORITY_BITS-1:0] prio_t;
  typedef logic [PRIO_OUT_W-1:0]    prio_out_t;
  typedef logic [REMOVED_W-1:0]     removed_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT       = 2'd0,
    MODE_LIST_ALL     = 2'd1,
    MODE_LIST_PENDING = 2'd2,
    MODE_PURGE        = 2'd3
  } mode_t;

  typedef struct packed {
    id_t   id;
    prio_t prio;
    logic  done;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    RD_ZERO,
    RD_IDX,
    RD_IDX_INC,
    RD_IDX_DEC,
    RD_IDX_DEC2
  } rd_src_t;

  typedef enum logic {WR_NEW, WR_RDATA} wr_src_t;
  typedef enum logic {WD_IDX, WD_WPTR} wr_dst_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_WPTR} cnt_op_t;

  typedef enum logic [1:0] {
    OUT_INS_OK,
    OUT_INS_FULL,
    OUT_PURGE,
    OUT_LIST_END
  } out_kind_t;

  typedef struct packed {
    logic      latch_in;
    logic      rd_en;
    rd_src_t   rd_src;
    logic      wr_en;
    wr_src_t   wr_src;
    wr_dst_t   wr_dst;
    idx_op_t   idx_op;
    logic      wptr_clr;
    logic      wptr_inc;
    cnt_op_t   cnt_op;
    logic      held_load;
    logic      held_push;
    logic      held_clr;
    logic      out_load;
    out_kind_t out_kind;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  cnt_zero;
    logic  cnt_full;
    logic  idx_last;
    logic  idx_one;
    logic  rd_ge;
    logic  rd_done;
    logic  held_valid;
    logic  out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sptt_in_if.sv =====
// Request channel of the task table: command and entry fields.
`default_nettype none

interface sptt_in_if;
  logic                           valid;
  logic                           ready;
  logic [sptt_pkg::MODE_W-1:0]    mode;
  logic [sptt_pkg::ID_W-1:0]      task_id;
  logic [sptt_pkg::PRIO_IN_W-1:0] priority_in;
  logic                           done_in;

  modport source (output valid, mode, task_id, priority_in, done_in, input ready);
  modport sink (input valid, mode, task_id, priority_in, done_in, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sptt_out_if.sv =====
// Result channel of the task table: listed entries and command responses.
`default_nettype none

interface sptt_out_if;
  logic                            valid;
  logic                            ready;
  logic [sptt_pkg::ID_W-1:0]       entry_id;
  logic [sptt_pkg::PRIO_OUT_W-1:0] entry_priority;
  logic                            entry_done;
  logic                            entry_valid;
  logic                            status;
  logic [sptt_pkg::REMOVED_W-1:0]  removed_count;
  logic                            last;

  modport source (output valid, entry_id, entry_priority, entry_done, entry_valid, status,
                  removed_count, last, input ready);
  modport sink (input valid, entry_id, entry_priority, entry_done, entry_valid, status,
                removed_count, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sptt_ram.sv =====
// Generic single write port, single registered read port RAM.
`default_nettype none

module sptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sptt_datapath.sv =====
// Datapath: entry store, walk counters, held entry and the result register.
`default_nettype none

module sptt_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire sptt_pkg::cmd_t                 cmd,
  output sptt_pkg::stat_t                     stat,
  input  wire logic [sptt_pkg::MODE_W-1:0]    req_mode,
  input  wire logic [sptt_pkg::ID_W-1:0]      req_task_id,
  input  wire logic [sptt_pkg::PRIO_IN_W-1:0] req_priority_in,
  input  wire logic                           req_done_in,
  sptt_out_if.source                          rsp
);

  typedef struct packed {
    sptt_pkg::id_t      id;
    sptt_pkg::prio_out_t prio;
    logic               done;
    logic               entry_valid;
    logic               status;
    sptt_pkg::removed_t removed;
    logic               last;
  } rsp_t;

  sptt_pkg::entry_t new_entry;
  sptt_pkg::entry_t held;
  sptt_pkg::entry_t rdata;
  sptt_pkg::entry_t wr_data;
  sptt_pkg::mode_t  mode;
  sptt_pkg::cnt_t   idx;
  sptt_pkg::cnt_t   wptr;
  sptt_pkg::cnt_t   count;
  sptt_pkg::cnt_t   idx_inc;
  sptt_pkg::cnt_t   idx_dec;
  sptt_pkg::cnt_t   idx_dec2;
  sptt_pkg::addr_t  rd_addr;
  sptt_pkg::addr_t  wr_addr;
  logic             held_valid;
  logic             out_valid;
  logic [sptt_pkg::ENTRY_W-1:0] ram_rdata;
  rsp_t             out_reg;
  rsp_t             out_next;

  assign idx_inc  = idx + sptt_pkg::cnt_t'(1);
  assign idx_dec  = idx - sptt_pkg::cnt_t'(1);
  assign idx_dec2 = idx - sptt_pkg::cnt_t'(2);
  assign rdata    = ram_rdata;

  always_comb begin
    case (cmd.rd_src)
      sptt_pkg::RD_ZERO:     rd_addr = '0;
      sptt_pkg::RD_IDX:      rd_addr = idx[sptt_pkg::ADDR_W-1:0];
      sptt_pkg::RD_IDX_INC:  rd_addr = idx_inc[sptt_pkg::ADDR_W-1:0];
      sptt_pkg::RD_IDX_DEC:  rd_addr = idx_dec[sptt_pkg::ADDR_W-1:0];
      sptt_pkg::RD_IDX_DEC2: rd_addr = idx_dec2[sptt_pkg::ADDR_W-1:0];
      default:               rd_addr = '0;
    endcase
  end

  assign wr_addr = (cmd.wr_dst == sptt_pkg::WD_WPTR) ? wptr[sptt_pkg::ADDR_W-1:0]
                                                     : idx[sptt_pkg::ADDR_W-1:0];
  assign wr_data = (cmd.wr_src == sptt_pkg::WR_NEW) ? new_entry : rdata;

  sptt_ram #(
    .WIDTH (sptt_pkg::ENTRY_W),
    .DEPTH (sptt_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // Result payload: a held entry pushed ahead of a later one, or a closing response.
  always_comb begin
    out_next = '0;
    if (cmd.held_push) begin
      out_next.id          = held.id;
      out_next.prio        = sptt_pkg::prio_out_t'(held.prio);
      out_next.done        = held.done;
      out_next.entry_valid = 1'b1;
    end else begin
      out_next.last = 1'b1;
      case (cmd.out_kind)
        sptt_pkg::OUT_INS_OK:   out_next.status = 1'b0;
        sptt_pkg::OUT_INS_FULL: out_next.status = 1'b1;
        sptt_pkg::OUT_PURGE:    out_next.removed = sptt_pkg::removed_t'(count - wptr);
        sptt_pkg::OUT_LIST_END: begin
          if (held_valid) begin
            out_next.id          = held.id;
            out_next.prio        = sptt_pkg::prio_out_t'(held.prio);
            out_next.done        = held.done;
            out_next.entry_valid = 1'b1;
          end
        end
        default: out_next.status = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      case (cmd.cnt_op)
        sptt_pkg::CNT_INC:  count <= count + sptt_pkg::cnt_t'(1);
        sptt_pkg::CNT_WPTR: count <= wptr;
        default:            count <= count;
      endcase
      if (cmd.held_clr) begin
        held_valid <= 1'b0;
      end else if (cmd.held_load) begin
        held_valid <= 1'b1;
      end
      if (cmd.held_push || cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      mode           <= sptt_pkg::mode_t'(req_mode);
      new_entry.id   <= req_task_id;
      new_entry.prio <= sptt_pkg::prio_t'(req_priority_in);
      new_entry.done <= req_done_in;
    end
    case (cmd.idx_op)
      sptt_pkg::IDX_ZERO:  idx <= '0;
      sptt_pkg::IDX_COUNT: idx <= count;
      sptt_pkg::IDX_INC:   idx <= idx_inc;
      sptt_pkg::IDX_DEC:   idx <= idx_dec;
      default:             idx <= idx;
    endcase
    if (cmd.wptr_clr) begin
      wptr <= '0;
    end else if (cmd.wptr_inc) begin
      wptr <= wptr + sptt_pkg::cnt_t'(1);
    end
    if (cmd.held_load) begin
      held <= rdata;
    end
    if (cmd.held_push || cmd.out_load) begin
      out_reg <= out_next;
    end
  end

  assign stat.mode       = mode;
  assign stat.cnt_zero   = (count == '0);
  assign stat.cnt_full   = (count == sptt_pkg::cnt_t'(sptt_pkg::DEPTH));
  assign stat.idx_last   = (idx == count - sptt_pkg::cnt_t'(1));
  assign stat.idx_one    = (idx == sptt_pkg::cnt_t'(1));
  assign stat.rd_ge      = (rdata.prio >= new_entry.prio);
  assign stat.rd_done    = rdata.done;
  assign stat.held_valid = held_valid;
  assign stat.out_free   = !out_valid || rsp.ready;

  assign rsp.valid          = out_valid;
  assign rsp.entry_id       = out_reg.id;
  assign rsp.entry_priority = out_reg.prio;
  assign rsp.entry_done     = out_reg.done;
  assign rsp.entry_valid    = out_reg.entry_valid;
  assign rsp.status         = out_reg.status;
  assign rsp.removed_count  = out_reg.removed;
  assign rsp.last           = out_reg.last;

endmodule

`default_nettype wire

// ===== hw/rtl/sptt_ctrl.sv =====
// Controller: sequences insert, listing and purge walks over the entry store.
`default_nettype none

module sptt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  output sptt_pkg::cmd_t       cmd,
  input  wire sptt_pkg::stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_WR,
    S_INS_LAST,
    S_PURGE_SCAN,
    S_LST_OUT,
    S_RESP
  } state_t;

  state_t              state;
  state_t              state_next;
  sptt_pkg::out_kind_t resp_kind;
  sptt_pkg::out_kind_t resp_kind_next;
  logic                show;

  assign req_ready = (state == S_IDLE);
  assign show      = (stat.mode == sptt_pkg::MODE_LIST_ALL) || !stat.rd_done;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    resp_kind_next = resp_kind;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.mode)
          sptt_pkg::MODE_INSERT: begin
            cmd.idx_op = sptt_pkg::IDX_COUNT;
            if (stat.cnt_full) begin
              resp_kind_next = sptt_pkg::OUT_INS_FULL;
              state_next     = S_RESP;
            end else if (stat.cnt_zero) begin
              state_next = S_INS_LAST;
            end else begin
              state_next = S_INS_RD;
            end
          end
          sptt_pkg::MODE_PURGE: begin
            cmd.idx_op     = sptt_pkg::IDX_ZERO;
            cmd.wptr_clr   = 1'b1;
            resp_kind_next = sptt_pkg::OUT_PURGE;
            if (stat.cnt_zero) begin
              state_next = S_RESP;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = sptt_pkg::RD_ZERO;
              state_next = S_PURGE_SCAN;
            end
          end
          default: begin
            cmd.idx_op     = sptt_pkg::IDX_ZERO;
            resp_kind_next = sptt_pkg::OUT_LIST_END;
            if (stat.cnt_zero) begin
              state_next = S_RESP;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = sptt_pkg::RD_ZERO;
              state_next = S_LST_OUT;
            end
          end
        endcase
      end
      S_INS_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = sptt_pkg::RD_IDX_DEC;
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        // Walk down from the top: shift each lower-priority entry up by one slot,
        // and drop the new entry in just above the first one that it must follow.
        cmd.wr_en  = 1'b1;
        cmd.wr_dst = sptt_pkg::WD_IDX;
        if (stat.rd_ge) begin
          cmd.wr_src     = sptt_pkg::WR_NEW;
          cmd.cnt_op     = sptt_pkg::CNT_INC;
          resp_kind_next = sptt_pkg::OUT_INS_OK;
          state_next     = S_RESP;
        end else begin
          cmd.wr_src = sptt_pkg::WR_RDATA;
          cmd.idx_op = sptt_pkg::IDX_DEC;
          if (stat.idx_one) begin
            state_next = S_INS_LAST;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = sptt_pkg::RD_IDX_DEC2;
          end
        end
      end
      S_INS_LAST: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_dst     = sptt_pkg::WD_IDX;
        cmd.wr_src     = sptt_pkg::WR_NEW;
        cmd.cnt_op     = sptt_pkg::CNT_INC;
        resp_kind_next = sptt_pkg::OUT_INS_OK;
        state_next     = S_RESP;
      end
      S_PURGE_SCAN: begin
        if (!stat.rd_done) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_dst   = sptt_pkg::WD_WPTR;
          cmd.wr_src   = sptt_pkg::WR_RDATA;
          cmd.wptr_inc = 1'b1;
        end
        if (stat.idx_last) begin
          state_next = S_RESP;
        end else begin
          cmd.idx_op = sptt_pkg::IDX_INC;
          cmd.rd_en  = 1'b1;
          cmd.rd_src = sptt_pkg::RD_IDX_INC;
        end
      end
      S_LST_OUT: begin
        // Each shown entry is held back one step, so that the last one can be
        // marked once the walk reaches the end of the table.
        if (!(show && stat.held_valid && !stat.out_free)) begin
          if (show) begin
            cmd.held_load = 1'b1;
            cmd.held_push = stat.held_valid;
          end
          if (stat.idx_last) begin
            state_next = S_RESP;
          end else begin
            cmd.idx_op = sptt_pkg::IDX_INC;
            cmd.rd_en  = 1'b1;
            cmd.rd_src = sptt_pkg::RD_IDX_INC;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = resp_kind;
          cmd.held_clr = 1'b1;
          if (resp_kind == sptt_pkg::OUT_PURGE) begin
            cmd.cnt_op = sptt_pkg::CNT_WPTR;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      resp_kind <= sptt_pkg::OUT_INS_OK;
    end else begin
      state     <= state_next;
      resp_kind <= resp_kind_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_priority_task_table.sv =====
// Top level of the sorted priority task table: controller plus datapath.
//
// The req channel carries one command per beat: insert an entry (task_id,
// priority_in, done_in), list all entries, list pending entries, or purge
// completed ones. Entries are kept in descending priority; equal priorities
// keep their arrival order. The rsp channel returns the results: one beat for
// insert (status 1 if the table was full) and for purge (removed_count), and
// one beat per shown entry for a listing, or a single beat with entry_valid 0
// when nothing is shown. The final beat of every command has last set.
// One command is handled at a time; req ready is high only between commands.
// The controller walks the entry store one slot a cycle through its single
// registered read port, except while a listing waits on rsp ready.
// A new command may be accepted while the closing beat of the last one still
// waits in the output register. If rsp ready is held low, a listing stops in
// place and resumes without loss. Reset empties the table and clears the
// output valid; stored entries are not cleared, only the count is.
`default_nettype none

module sorted_priority_task_table (
  input wire logic  clk,
  input wire logic  rst,
  sptt_in_if.sink   req,
  sptt_out_if.source rsp
);

  sptt_pkg::cmd_t  cmd;
  sptt_pkg::stat_t stat;

  sptt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sptt_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .req_mode        (req.mode),
    .req_task_id     (req.task_id),
    .req_priority_in (req.priority_in),
    .req_done_in     (req.done_in),
    .rsp             (rsp)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sptt_checker.sv =====
// Port-level checks for the task table, bound to the top level.
`default_nettype none

module sptt_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic [sptt_pkg::ID_W-1:0]       rsp_entry_id,
  input wire logic [sptt_pkg::PRIO_OUT_W-1:0] rsp_entry_priority,
  input wire logic                            rsp_entry_done,
  input wire logic                            rsp_entry_valid,
  input wire logic                            rsp_status,
  input wire logic [sptt_pkg::REMOVED_W-1:0]  rsp_removed_count,
  input wire logic                            rsp_last
);

  // Reset leaves no result beat pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // Only listed entries may be followed by more beats of the same command.
  a_mid_is_entry: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> rsp_entry_valid)
    else $error("non-final beat without an entry");

  // An entry beat never carries a status or purge count.
  a_entry_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_entry_valid |-> !rsp_status && rsp_removed_count == '0)
    else $error("entry beat with status or removed count");

  // The table handles one command at a time.
  a_one_cmd: assert property (@(posedge clk)
    !rst && req_valid && req_ready |=> !req_ready)
    else $error("request ready right after an accepted command");

  a_rsp_hold: assert property (@(posedge clk)
    !rst && rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_id) &&
      $stable(rsp_entry_priority) && $stable(rsp_entry_done) &&
      $stable(rsp_entry_valid) && $stable(rsp_status) &&
      $stable(rsp_removed_count) && $stable(rsp_last))
    else $error("stalled result beat changed");

endmodule

bind sorted_priority_task_table sptt_checker u_sptt_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_entry_id       (rsp.entry_id),
  .rsp_entry_priority (rsp.entry_priority),
  .rsp_entry_done     (rsp.entry_done),
  .rsp_entry_valid    (rsp.entry_valid),
  .rsp_status         (rsp.status),
  .rsp_removed_count  (rsp.removed_count),
  .rsp_last           (rsp.last)
);

`default_nettype wire
